// ===== design/dlbh_pkg.sv =====
// ============================================================================
// dlbh_pkg
// Shared types, constants and round functions for the double-lane block hash.
// ============================================================================
package dlbh_pkg;

    localparam int WORD_W      = 64;
    localparam int BLOCK_WORDS = 18;
    localparam int IDX_W       = 5;
    localparam int RND_W       = 5;
    localparam int OIDX_W      = 4;

    localparam logic [IDX_W-1:0]  LAST_SLOT    = 5'd17;
    localparam logic [OIDX_W-1:0] LAST_OUT_IDX = 4'd15;
    localparam logic [WORD_W-1:0] PAD_WORD     = 64'h80;
    localparam logic [WORD_W-1:0] G_INIT_WORD8 = 64'd11;

    // Nine 64-bit words of one 3x3 array, word 0 in the lowest position.
    typedef logic [8:0][WORD_W-1:0] lane_t;

    // Source of a word written into the block store.
    typedef enum logic [1:0] {
        SRC_RAW    = 2'd0,
        SRC_MASKED = 2'd1,
        SRC_PAD    = 2'd2
    } src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_en;
        src_t              wr_src;
        logic [IDX_W-1:0]  wr_idx;
        logic              init_en;
        logic              init_last;
        logic              round_en;
        logic [RND_W-1:0]  rnd;
        logic              final_en;
        logic              chain_clr;
        logic [OIDX_W-1:0] out_idx;
    } dlbh_cmd_t;

    localparam logic [5:0] ROT_EVEN [9] = '{6'd0, 6'd3, 6'd6, 6'd9, 6'd12, 6'd15,
                                            6'd18, 6'd21, 6'd24};
    localparam logic [5:0] ROT_ODD  [9] = '{6'd0, 6'd24, 6'd48, 6'd8, 6'd32, 6'd56,
                                            6'd16, 6'd40, 6'd7};
    localparam logic [5:0] ROT_K1   [9] = '{6'd1, 6'd5, 6'd11, 6'd17, 6'd0, 6'd31,
                                            6'd41, 6'd47, 6'd59};
    localparam logic [5:0] ROT_K2   [9] = '{6'd3, 6'd7, 6'd19, 6'd43, 6'd53, 6'd61,
                                            6'd0, 6'd29, 6'd37};
    // Word shuffles of the key schedule: new word n takes old word PERM[n].
    localparam logic [3:0] PERM_A   [9] = '{4'd0, 4'd4, 4'd8, 4'd2, 4'd3, 4'd7,
                                            4'd1, 4'd5, 4'd6};
    localparam logic [3:0] PERM_B   [9] = '{4'd0, 4'd6, 4'd3, 4'd4, 4'd1, 4'd7,
                                            4'd8, 4'd5, 4'd2};

    // Round constant of round n.
    function automatic logic [7:0] round_const(input logic [RND_W-1:0] n);
        logic [7:0] c;
        unique case (n)
            5'd0:  c = 8'h24;  5'd1:  c = 8'h3f;  5'd2:  c = 8'h6a;  5'd3:  c = 8'h88;
            5'd4:  c = 8'h85;  5'd5:  c = 8'ha3;  5'd6:  c = 8'h08;  5'd7:  c = 8'hd3;
            5'd8:  c = 8'h13;  5'd9:  c = 8'h19;  5'd10: c = 8'h8a;  5'd11: c = 8'h2e;
            5'd12: c = 8'h03;  5'd13: c = 8'h70;  5'd14: c = 8'h73;  5'd15: c = 8'h44;
            5'd16: c = 8'ha4;  5'd17: c = 8'h09;  5'd18: c = 8'h38;  5'd19: c = 8'h22;
            5'd20: c = 8'h29;  5'd21: c = 8'h9f;  5'd22: c = 8'h31;  5'd23: c = 8'hd0;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                 input logic [5:0] n);
        logic [2*WORD_W-1:0] d;
        d = {x, x} << n;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    // Three-word S-box applied to row r of an array.
    function automatic lane_t sbox_row(input lane_t w, input int r);
        lane_t o;
        o = w;
        o[r*3]   = (w[r*3+1] & w[r*3+2]) ^ w[r*3];
        o[r*3+1] = (o[r*3] & w[r*3+2]) ^ w[r*3+1];
        o[r*3+2] = (o[r*3] | o[r*3+1]) ^ w[r*3+2];
        return o;
    endfunction

endpackage

// ===== design/double_lane_block_hash_1024_core.sv =====
// ============================================================================
// double_lane_block_hash_1024_core
// Streaming 1024-bit block hash over 64-bit message words.
// ============================================================================
// Message words are accepted one per cycle while the block collects its
// eighteen-word block. A full block is then compressed in a load step, the
// rounds of the shared two-lane round unit and a feed-forward step, during
// which no word is accepted. The final word adds padding (an extra pad step
// when it is a full word, another compression when the pad spills into a new
// block) and is followed by sixteen digest transfers, g words 0..7 then h
// words 0..7, the last marked by m_tlast. The chains then return to their
// start values for the next message.
module double_lane_block_hash_1024_core import dlbh_pkg::*; #(
    parameter int ROUNDS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] msg_word, [70:64] valid_bits, [71] zero
    input  logic        s_tlast,   // final_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic        m_tlast    // digest_last
);

    dlbh_cmd_t cmd;

    dlbh_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_final     (s_tlast),
        .in_full_word (s_tdata[70]),
        .in_ready     (s_tready),
        .out_valid    (m_tvalid),
        .out_last     (m_tlast),
        .out_ready    (m_tready),
        .cmd          (cmd)
    );

    dlbh_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_word  (s_tdata[63:0]),
        .in_bits  (s_tdata[70:64]),
        .out_word (m_tdata)
    );

endmodule

// ===== design/dlbh_ctrl.sv =====
// ============================================================================
// dlbh_ctrl
// Controller: counts words into the block, sequences padding, the rounds of
// the compression and the sixteen digest transfers.
// ============================================================================
module dlbh_ctrl import dlbh_pkg::*; #(
    parameter int ROUNDS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      in_final,
    input  logic      in_full_word,
    output logic      in_ready,
    output logic      out_valid,
    output logic      out_last,
    input  logic      out_ready,
    output dlbh_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_INIT,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [OIDX_W-1:0] oidx_reg, oidx_next;
    logic              last_reg, last_next;
    logic              pad_reg, pad_next;
    logic              out_reg, out_next;

    logic in_xfer, out_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_xfer  = out_valid && out_ready;
    assign out_last  = (oidx_reg == LAST_OUT_IDX);

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        oidx_next  = oidx_reg;
        last_next  = last_reg;
        pad_next   = pad_reg;
        out_next   = out_reg;
        cmd        = '0;
        cmd.wr_idx    = cnt_reg;
        cmd.wr_src    = SRC_RAW;
        cmd.init_last = last_reg;
        cmd.rnd       = rnd_reg;
        cmd.out_idx   = oidx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd.wr_en = 1'b1;
                    if (in_final && !in_full_word) begin
                        // Partial final word carries its own pad bit.
                        cmd.wr_src = SRC_MASKED;
                        cnt_next   = '0;
                        last_next  = 1'b1;
                        out_next   = 1'b1;
                        state_next = ST_INIT;
                    end else if (cnt_reg == LAST_SLOT) begin
                        cnt_next   = '0;
                        last_next  = 1'b0;
                        pad_next   = in_final;
                        state_next = ST_INIT;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        if (in_final) begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_PAD;
                cnt_next   = '0;
                last_next  = 1'b1;
                pad_next   = 1'b0;
                out_next   = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.init_en = 1'b1;
                rnd_next    = '0;
                state_next  = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 1'b1;
                if (rnd_reg == LAST_RND) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.final_en = 1'b1;
                oidx_next    = '0;
                priority if (pad_reg) begin
                    state_next = ST_PAD;
                end else if (out_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    oidx_next = oidx_reg + 1'b1;
                    if (out_last) begin
                        cmd.chain_clr = 1'b1;
                        out_next      = 1'b0;
                        last_next     = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            last_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            out_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
            last_reg  <= last_next;
            pad_reg   <= pad_next;
            out_reg   <= out_next;
        end
    end

endmodule

// ===== design/dlbh_datapath.sv =====
// ============================================================================
// dlbh_datapath
// Datapath: block store, chain registers, key schedule and the two lanes of
// the permutation, one round per cycle.
// ============================================================================
module dlbh_datapath import dlbh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dlbh_cmd_t         cmd,
    input  logic [WORD_W-1:0] in_word,
    input  logic [6:0]        in_bits,
    output logic [WORD_W-1:0] out_word
);

    logic [WORD_W-1:0] blk_reg [BLOCK_WORDS];
    lane_t g_reg, g_next;
    lane_t h_reg, h_next;
    lane_t sg_reg, sg_next, sh_reg, sh_next;
    lane_t k0_reg, k0_next, k1_reg, k1_next, k2_reg, k2_next;

    logic [WORD_W-1:0] masked_word, wr_word;
    lane_t g_eff, kin;

    // Clear the bits past the last valid one and place the pad bit after it.
    always_comb begin
        logic [2:0]  q, r;
        logic [15:0] part;
        q    = in_bits[5:3];
        r    = in_bits[2:0];
        part = 16'h00ff << (4'd8 - {1'b0, r});
        for (int b = 0; b < 8; b++) begin
            if (3'(b) < q) begin
                masked_word[b*8 +: 8] = in_word[b*8 +: 8];
            end else if (3'(b) == q) begin
                masked_word[b*8 +: 8] = (in_word[b*8 +: 8] & part[7:0]) | (8'h80 >> r);
            end else begin
                masked_word[b*8 +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        unique case (cmd.wr_src)
            SRC_MASKED: wr_word = masked_word;
            SRC_PAD:    wr_word = PAD_WORD;
            default:    wr_word = in_word;
        endcase
    end

    // Block store: one slot written; padding writes zero every later slot.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            if (cmd.wr_en) begin
                if (IDX_W'(i) == cmd.wr_idx) begin
                    blk_reg[i] <= wr_word;
                end else if (IDX_W'(i) > cmd.wr_idx && cmd.wr_src != SRC_RAW) begin
                    blk_reg[i] <= '0;
                end
            end
        end
    end

    // Initial whitening of both lanes with the three keys.
    always_comb begin
        g_eff = g_reg;
        if (cmd.init_last) begin
            g_eff[8] = g_reg[8] ^ 64'd2;
        end
        for (int i = 0; i < 9; i++) begin
            kin[i] = h_reg[i] ^ blk_reg[i] ^ blk_reg[i+9];
        end
    end

    // One round of the key schedule and of both lanes.
    always_comb begin
        lane_t a, b, c, s, t;
        logic [WORD_W-1:0] col0, col1, col2, u0, u1, u2;
        logic              odd;
        odd = cmd.rnd[0];
        b   = sbox_row(k1_reg, 0);
        c   = sbox_row(k2_reg, 0);
        for (int n = 0; n < 9; n++) begin
            k0_next[n] = k0_reg[PERM_A[n]];
            k1_next[n] = rotl64(b[PERM_B[n]], ROT_K1[n]);
            k2_next[n] = rotl64(c[PERM_A[n]], ROT_K2[n]);
        end
        k2_next[0] = k2_next[0] ^ {56'd0, round_const(cmd.rnd)};
        for (int l = 0; l < 2; l++) begin
            a = (l == 0) ? sg_reg : sh_reg;
            a = sbox_row(a, 0);
            a = sbox_row(a, 1);
            a = sbox_row(a, 2);
            col0 = a[0] ^ a[3] ^ a[6];
            col1 = a[1] ^ a[4] ^ a[7];
            col2 = a[2] ^ a[5] ^ a[8];
            u0 = col2;
            u1 = col0 ^ col2;
            u2 = col1;
            for (int i = 0; i < 3; i++) begin
                s[i*3]   = a[i*3]   ^ u0;
                s[i*3+1] = a[i*3+1] ^ u1;
                s[i*3+2] = a[i*3+2] ^ u2;
            end
            for (int n = 0; n < 9; n++) begin
                t[n] = rotl64(s[n], odd ? ROT_ODD[n] : ROT_EVEN[n])
                       ^ k0_next[n] ^ k1_next[n] ^ k2_next[n];
            end
            if (l == 0) begin
                sg_next = t;
            end else begin
                sh_next = t;
            end
        end
    end

    // Feed-forward into the new chains.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            g_next[i] = sg_reg[i] ^ g_reg[i];
            h_next[i] = sh_reg[i] ^ g_reg[i];
        end
        h_next[8] = h_next[8] ^ 64'd1;
    end

    // Chain registers.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.chain_clr) begin
            g_reg <= {G_INIT_WORD8, {(8*WORD_W){1'b0}}};
            h_reg <= '0;
        end else if (cmd.init_en) begin
            g_reg <= g_eff;
        end else if (cmd.final_en) begin
            g_reg <= g_next;
            h_reg <= h_next;
        end
    end

    // Lane and key registers.
    always_ff @(posedge aclk) begin
        if (cmd.init_en) begin
            for (int i = 0; i < 9; i++) begin
                sg_reg[i] <= g_eff[i] ^ kin[i];
                sh_reg[i] <= g_eff[i] ^ kin[i] ^ ((i == 8) ? 64'd1 : 64'd0);
                k0_reg[i] <= h_reg[i];
                k1_reg[i] <= blk_reg[i];
                k2_reg[i] <= blk_reg[i+9];
            end
        end else if (cmd.round_en) begin
            sg_reg <= sg_next;
            sh_reg <= sh_next;
            k0_reg <= k0_next;
            k1_reg <= k1_next;
            k2_reg <= k2_next;
        end
    end

    assign out_word = cmd.out_idx[3] ? h_reg[cmd.out_idx[2:0]] : g_reg[cmd.out_idx[2:0]];

endmodule

// ===== design/dlbh_checker.sv =====
// ============================================================================
// dlbh_checker
// Port-level checks of the hash core, bound to the top level.
// ============================================================================
module dlbh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    // No message word is taken while the digest is being delivered.
    a_no_input_during_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while digest is pending");

    // A stalled digest word holds.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("digest word changed under stall");

    // The last digest transfer closes the output.
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output continued after last digest word");

    // A final word always starts padding or compression first.
    a_final_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (!s_tready && !m_tvalid))
        else $error("core idle right after final word");

endmodule

bind double_lane_block_hash_1024_core dlbh_checker u_dlbh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the double-lane 1024-bit block hash core.
// ============================================================================
// Messages of random length and content are streamed into the core. A
// behavioral model of the hash computes the sixteen digest words of every
// message. Each digest transfer is compared with the oldest pending word.
// The run goes through phases of sender idling and receiver stalls.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dlbh_pkg::*;

    typedef struct {
        logic [63:0] data;
        logic [6:0]  nbits;
        logic        fin;
    } msg_word_t;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } digest_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    msg_word_t   word_queue[$];
    digest_t     digest_queue[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        in_taken = 1'b0;

    // Model state of the hash.
    lane_t       hg, hh;
    logic [63:0] hblk [18];
    int          hcnt;

    localparam logic [7:0] RCON [24] = '{
        8'h24, 8'h3f, 8'h6a, 8'h88, 8'h85, 8'ha3, 8'h08, 8'hd3, 8'h13, 8'h19, 8'h8a, 8'h2e,
        8'h03, 8'h70, 8'h73, 8'h44, 8'ha4, 8'h09, 8'h38, 8'h22, 8'h29, 8'h9f, 8'h31, 8'hd0
    };

    double_lane_block_hash_1024_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic logic [63:0] rot_left(input logic [63:0] x, input int n);
        n = n & 63;
        if (n == 0) return x;
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic lane_t mix_row(input lane_t w, input int r);
        logic [63:0] a, b, c;
        a = w[r*3] ^ (w[r*3+1] & w[r*3+2]);
        b = w[r*3+1] ^ (a & w[r*3+2]);
        c = w[r*3+2] ^ (a | b);
        w[r*3] = a;
        w[r*3+1] = b;
        w[r*3+2] = c;
        return w;
    endfunction

    // Keyed 3x3 permutation with the rotating key schedule.
    function automatic lane_t scramble(input lane_t s, input lane_t k0, input lane_t k1,
                                       input lane_t k2);
        lane_t t;
        logic [63:0] col [3];
        logic [63:0] mx [3];
        for (int i = 0; i < 9; i++) s[i] ^= k0[i] ^ k1[i] ^ k2[i];
        for (int rnd = 0; rnd < 16; rnd++) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) t[i*3+j] = k0[j*3 + (2*i+j) % 3];
            k0 = t;
            k1 = mix_row(k1, 0);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) t[i*3+j] = k1[((i + 2*j) % 3)*3 + i];
            for (int i = 0; i < 9; i++) k1[i] = rot_left(t[i], ROT_K1[i]);
            k2 = mix_row(k2, 0);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) t[i*3+j] = k2[j*3 + (2*i+j) % 3];
            for (int i = 0; i < 9; i++) k2[i] = rot_left(t[i], ROT_K2[i]);
            k2[0] ^= {56'd0, RCON[rnd % 24]};
            for (int i = 0; i < 3; i++) s = mix_row(s, i);
            for (int j = 0; j < 3; j++) col[j] = s[j] ^ s[3+j] ^ s[6+j];
            mx[0] = col[2];
            mx[1] = col[0] ^ col[2];
            mx[2] = col[1];
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) s[i*3+j] ^= mx[j];
            for (int i = 0; i < 9; i++)
                s[i] = rot_left(s[i], (rnd & 1) ? ROT_ODD[i] : ROT_EVEN[i]);
            for (int i = 0; i < 9; i++) s[i] ^= k0[i] ^ k1[i] ^ k2[i];
        end
        return s;
    endfunction

    task automatic hash_restart();
        hg = '0;
        hh = '0;
        hg[8] = 64'd11;
        hcnt = 0;
    endtask

    task automatic absorb_block(input logic last);
        lane_t sg, sh, kb0, kb1;
        if (last) hg[8] ^= 64'd2;
        for (int i = 0; i < 9; i++) begin
            kb0[i] = hblk[i];
            kb1[i] = hblk[9+i];
        end
        sh = hg;
        sh[8] ^= 64'd1;
        sg = scramble(hg, hh, kb0, kb1);
        sh = scramble(sh, hh, kb0, kb1);
        for (int i = 0; i < 9; i++) begin
            hh[i] = sh[i] ^ hg[i] ^ ((i == 8) ? 64'd1 : 64'd0);
            hg[i] = sg[i] ^ hg[i];
        end
        hcnt = 0;
    endtask

    // Advance the model by one accepted word; a final word queues the digest.
    task automatic hash_word(input logic [63:0] w, input logic [6:0] nbits, input logic fin);
        int q, r;
        logic [63:0] keep;
        logic [7:0] mb;
        if (!fin || nbits >= 64) begin
            if (hcnt >= 18) hcnt = 0;
            hblk[hcnt] = w;
            hcnt++;
            if (hcnt == 18) absorb_block(!fin ? 1'b0 : 1'b0);
            if (!fin) return;
            // Pad byte goes into the next slot, or a fresh block.
            hblk[hcnt] = 64'h80;
            for (int k = hcnt + 1; k < 18; k++) hblk[k] = '0;
        end else begin
            q = nbits >> 3;
            r = nbits & 7;
            keep = (q == 0) ? 64'd0 : ({64{1'b1}} >> (64 - 8*q));
            mb = 8'hff << (8 - r);
            keep |= {56'd0, mb} << (8*q);
            w = (w & keep) | ({56'd0, 8'h80 >> r} << (8*q));
            if (hcnt >= 18) hcnt = 0;
            hblk[hcnt] = w;
            for (int k = hcnt + 1; k < 18; k++) hblk[k] = '0;
        end
        absorb_block(1'b1);
        for (int k = 0; k < 8; k++) digest_queue.push_back('{hg[k], 1'b0});
        for (int k = 0; k < 8; k++) digest_queue.push_back('{hh[k], k == 7});
        hash_restart();
    endtask

    // Input side: change at the falling edge, hold until the transfer is seen.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= {1'b0, word_queue[0].nbits, word_queue[0].data};
                    s_tlast <= word_queue[0].fin;
                    s_tvalid <= 1'b1;
                    void'(word_queue.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            hash_word(s_tdata[63:0], s_tdata[70:64], s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected digest transfer %h last %b", $time, m_tdata, m_tlast);
            end else begin
                if (m_tdata !== digest_queue[0].word || m_tlast !== digest_queue[0].last) begin
                    errors++;
                    $display("%0t: digest mismatch expected %h/%b actual %h/%b", $time,
                             digest_queue[0].word, digest_queue[0].last, m_tdata, m_tlast);
                end
                void'(digest_queue.pop_front());
            end
        end
    end

    task automatic add_message(input int nwords, input int last_bits);
        for (int i = 0; i < nwords; i++)
            word_queue.push_back('{{$urandom, $urandom}, 7'($urandom_range(127)), 1'b0});
        word_queue.push_back('{{$urandom, $urandom}, 7'(last_bits), 1'b1});
    endtask

    task automatic add_random_message();
        int n, lb, pick;
        pick = $urandom_range(9);
        if (pick < 6) n = $urandom_range(12);
        else if (pick < 9) n = 16 + $urandom_range(3);
        else n = 34 + $urandom_range(3);
        pick = $urandom_range(9);
        if (pick < 4) lb = 64;
        else if (pick < 9) lb = $urandom_range(63);
        else lb = 65 + $urandom_range(62);
        add_message(n, lb);
    endtask

    task automatic drain();
        wait (word_queue.size() == 0 && !s_tvalid && digest_queue.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        int stall [4];
        int idle [4];
        stall = '{0, 0, 82, 30};
        idle = '{0, 82, 0, 30};
        hash_restart();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty message, edge lengths, partial and oversized final words.
        word_queue.push_back('{64'hffff_ffff_ffff_ffff, 7'd0, 1'b1});
        add_message(0, 64);
        add_message(0, 1);
        add_message(0, 7);
        add_message(0, 63);
        add_message(0, 127);
        add_message(1, 8);
        add_message(16, 64);
        add_message(17, 64);
        add_message(17, 0);
        add_message(18, 33);
        word_queue.push_back('{64'h0, 7'd64, 1'b1});
        word_queue.push_back('{64'hffff_ffff_ffff_ffff, 7'd100, 1'b1});
        drain();

        // Random messages under each idling pattern.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle[p];
            recv_stall_pct = stall[p];
            while (word_queue.size() < 75) add_random_message();
            drain();
        end

        if (errors == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule

// ===== double_lane_block_hash_1024_core.f =====
design/dlbh_pkg.sv
design/dlbh_ctrl.sv
design/dlbh_datapath.sv
design/double_lane_block_hash_1024_core.sv
design/dlbh_checker.sv
test/tb_top.sv
